// ===== rtl/core/sfs_pkg.sv =====
// types, codes and constants shared by the sprite frame sequencer modules
`default_nettype none

package sfs_pkg;

    // item modes
    typedef enum logic [2:0] {
        MODE_APPEND    = 3'd0,
        MODE_SELECT    = 3'd1,
        MODE_SET_FRAME = 3'd2,
        MODE_NEXT      = 3'd3,
        MODE_PREV      = 3'd4
    } t_mode;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_COLUMNS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_DELAY   = 3'd5;
    localparam int unsigned CFG_DATA_W = 16;

    // field widths
    localparam int unsigned DIVIDEND_W = 16;
    localparam int unsigned DIVISOR_W  = 9;
    localparam int unsigned DIV_STEPS  = DIVIDEND_W;

    // configuration registers as seen by the sequencer
    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [10:0] cell_width;
        logic [10:0] cell_height;
        logic [8:0]  strip_columns;
        logic [15:0] frame_delay;
    } t_cfg;

    // countdown reload on a frame_delay write
    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } t_delay_load;

    // divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

    // one result transaction
    typedef struct packed {
        logic [3:0]  anim;
        logic [7:0]  frame;
        logic [19:0] rect_x;
        logic [22:0] rect_y;
        logic        changed;
        logic        rejected;
    } t_result;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_WRAP_GO,
        S_WRAP_RUN,
        S_CELL_GO,
        S_CELL_RUN,
        S_MUL_X,
        S_MUL_Y,
        S_ADD_Y,
        S_DONE
    } t_seq_state;

endpackage

`default_nettype wire

// ===== rtl/core/sfs_divider.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module sfs_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sfs_pkg::t_div_req i_req,
    output sfs_pkg::t_div_rsp      o_rsp
);

    localparam int unsigned DW  = sfs_pkg::DIVIDEND_W;
    localparam int unsigned VW  = sfs_pkg::DIVISOR_W;
    localparam int unsigned CNW = $clog2(sfs_pkg::DIV_STEPS);
    localparam logic [CNW-1:0] LAST_STEP = CNW'(sfs_pkg::DIV_STEPS - 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [VW-1:0]  r_rem;
    logic [DW-1:0]  r_quo;
    logic [VW-1:0]  r_div;

    logic [VW:0]    trial;
    logic           fits;
    logic [VW:0]    diff;

    // trial subtract of the next dividend bit
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        fits  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

// ===== rtl/core/sfs_seq.sv =====
// sequencer: entry table, animation state and cell placement
`default_nettype none

module sfs_seq #(
    parameter int unsigned MAX_ANIMATIONS   = 16,
    parameter int unsigned MAX_ENTRY_LENGTH = 255
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sfs_pkg::t_cfg        i_cfg,
    input  wire sfs_pkg::t_delay_load i_delay_load,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [2:0]           i_mode,
    input  wire logic signed [15:0]   i_anim_index,
    input  wire logic signed [15:0]   i_frame_number,
    input  wire logic [7:0]           i_entry_length,
    output logic                      o_res_valid,
    input  wire logic                 i_res_take,
    output sfs_pkg::t_result          o_res
);

    localparam int unsigned AW = (MAX_ANIMATIONS > 1) ? $clog2(MAX_ANIMATIONS) : 1;
    localparam int unsigned CW = $clog2(MAX_ANIMATIONS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ANIMATIONS);
    localparam logic [7:0] LEN_CAP =
        (MAX_ENTRY_LENGTH > 255) ? 8'd255 : 8'(MAX_ENTRY_LENGTH);

    sfs_pkg::t_seq_state r_state, n_state;

    logic [CW-1:0]       r_count;
    logic [11:0]         r_next_start;
    logic [AW-1:0]       r_sel_anim;
    logic [7:0]          r_sel_frame;
    logic [15:0]         r_countdown;
    logic [19:0]         r_cell_x;
    logic [22:0]         r_cell_y;
    logic                r_changed;
    logic                r_rejected;

    logic [AW-1:0]       r_anim_tgt;
    logic signed [15:0]  r_freq;
    logic [7:0]          r_frame_new;
    logic [23:0]         r_prod;
    logic [19:0]         r_rd_data;

    logic [19:0]         mem [MAX_ANIMATIONS];

    sfs_pkg::t_div_req   div_req;
    sfs_pkg::t_div_rsp   div_rsp;

    logic                in_accept;
    logic                is_append, is_pick, is_step;
    logic                have_entries, table_full;
    logic [7:0]          len_sat;
    logic [15:0]         cd_dec;
    logic [AW-1:0]       clamp_anim;
    logic                place_req;
    logic [7:0]          rd_len;
    logic [11:0]         rd_start;
    logic                freq_neg;
    logic [15:0]         freq_mag;
    logic [7:0]          wrapped;
    logic [12:0]         abs_frame;
    logic [8:0]          cols;
    logic [12:0]         mul_a;
    logic [10:0]         mul_b;
    logic [23:0]         product;
    logic [AW+3:0]       anim_ext;
    logic signed [15:0]  frame_ext;

    // item decode
    always_comb begin
        in_accept    = i_in_valid && !o_in_stall;
        is_append    = (i_mode == sfs_pkg::MODE_APPEND);
        is_pick      = (i_mode == sfs_pkg::MODE_SELECT) ||
                       (i_mode == sfs_pkg::MODE_SET_FRAME);
        is_step      = (i_mode == sfs_pkg::MODE_NEXT) ||
                       (i_mode == sfs_pkg::MODE_PREV);
        have_entries = (r_count != '0);
        table_full   = (r_count >= MAX_CNT);
        len_sat      = (i_entry_length > LEN_CAP) ? LEN_CAP : i_entry_length;
        cd_dec       = r_countdown - 16'd1;
        frame_ext    = signed'({8'd0, r_sel_frame});
        place_req    = in_accept && have_entries &&
                       (is_pick || (is_step && (cd_dec == 16'd0)));
    end

    // clamp the requested animation into the loaded range
    always_comb begin
        if (i_anim_index[15]) begin
            clamp_anim = '0;
        end else if (16'(r_count) <= i_anim_index[15:0]) begin
            clamp_anim = AW'(r_count - 1'b1);
        end else begin
            clamp_anim = i_anim_index[AW-1:0];
        end
    end

    // entry table: start frame and length per entry
    always_ff @(posedge i_clk) begin
        if (in_accept && is_append && !table_full) begin
            mem[r_count[AW-1:0]] <= {r_next_start, len_sat};
        end
        r_rd_data <= mem[r_anim_tgt];
    end

    // wrap and cell arithmetic around the shared divider
    always_comb begin
        rd_start  = r_rd_data[19:8];
        rd_len    = r_rd_data[7:0];
        freq_neg  = r_freq[15];
        freq_mag  = freq_neg ? 16'(-r_freq) : 16'(r_freq);
        wrapped   = (freq_neg && (div_rsp.remainder != '0)) ?
                    rd_len - div_rsp.remainder[7:0] : div_rsp.remainder[7:0];
        abs_frame = 13'(rd_start) + 13'(r_frame_new);
        cols      = (i_cfg.strip_columns == 9'd0) ? 9'd1 : i_cfg.strip_columns;
        mul_a     = (r_state == sfs_pkg::S_MUL_X) ? 13'(div_rsp.remainder)
                                                  : div_rsp.quotient[12:0];
        mul_b     = (r_state == sfs_pkg::S_MUL_X) ? i_cfg.cell_width
                                                  : i_cfg.cell_height;
        product   = 24'(mul_a) * 24'(mul_b);
    end

    // countdown: reload on a frame_delay write or a recompute, step on next and prev
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= 16'd1;
        end else if (i_delay_load.load) begin
            r_countdown <= i_delay_load.value;
        end else if (r_state == sfs_pkg::S_ADD_Y) begin
            r_countdown <= i_cfg.frame_delay;
        end else if ((r_state == sfs_pkg::S_IDLE) && in_accept && is_step) begin
            r_countdown <= ((cd_dec == 16'd0) && !have_entries) ? i_cfg.frame_delay
                                                                : cd_dec;
        end
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sfs_pkg::S_IDLE;
            r_count      <= '0;
            r_next_start <= '0;
            r_sel_anim   <= '0;
            r_sel_frame  <= '0;
            r_cell_x     <= '0;
            r_cell_y     <= '0;
            r_changed    <= 1'b0;
            r_rejected   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                sfs_pkg::S_IDLE: begin
                    if (in_accept) begin
                        r_changed  <= 1'b0;
                        r_rejected <= is_append && table_full;
                        if (is_append && !table_full) begin
                            r_next_start <= r_next_start + 12'(len_sat);
                            r_count      <= r_count + 1'b1;
                        end else if (is_pick) begin
                            r_anim_tgt <= (i_mode == sfs_pkg::MODE_SELECT) ?
                                          clamp_anim : r_sel_anim;
                            r_freq     <= i_frame_number;
                        end else if (is_step) begin
                            r_anim_tgt  <= r_sel_anim;
                            r_freq      <= (i_mode == sfs_pkg::MODE_NEXT) ?
                                           frame_ext + 16'sd1 : frame_ext - 16'sd1;
                        end
                    end
                end
                sfs_pkg::S_WRAP_GO: begin
                    if (rd_len == 8'd0) begin
                        r_frame_new <= 8'd0;
                    end
                end
                sfs_pkg::S_WRAP_RUN: begin
                    if (div_rsp.done) begin
                        r_frame_new <= wrapped;
                    end
                end
                sfs_pkg::S_MUL_X: begin
                    r_prod <= product;
                end
                sfs_pkg::S_MUL_Y: begin
                    r_cell_x <= 20'(i_cfg.origin_x) + r_prod[19:0];
                    r_prod   <= product;
                end
                sfs_pkg::S_ADD_Y: begin
                    r_cell_y    <= 23'(i_cfg.origin_y) + r_prod[22:0];
                    r_sel_anim  <= r_anim_tgt;
                    r_sel_frame <= r_frame_new;
                    r_changed   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfs_pkg::S_IDLE: begin
                if (place_req) begin
                    n_state = sfs_pkg::S_READ;
                end else if (in_accept) begin
                    n_state = sfs_pkg::S_DONE;
                end
            end
            sfs_pkg::S_READ:     n_state = sfs_pkg::S_WRAP_GO;
            sfs_pkg::S_WRAP_GO: begin
                n_state = (rd_len == 8'd0) ? sfs_pkg::S_CELL_GO : sfs_pkg::S_WRAP_RUN;
            end
            sfs_pkg::S_WRAP_RUN: begin
                if (div_rsp.done) begin
                    n_state = sfs_pkg::S_CELL_GO;
                end
            end
            sfs_pkg::S_CELL_GO:  n_state = sfs_pkg::S_CELL_RUN;
            sfs_pkg::S_CELL_RUN: begin
                if (div_rsp.done) begin
                    n_state = sfs_pkg::S_MUL_X;
                end
            end
            sfs_pkg::S_MUL_X:    n_state = sfs_pkg::S_MUL_Y;
            sfs_pkg::S_MUL_Y:    n_state = sfs_pkg::S_ADD_Y;
            sfs_pkg::S_ADD_Y:    n_state = sfs_pkg::S_DONE;
            sfs_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = sfs_pkg::S_IDLE;
                end
            end
            default:             n_state = sfs_pkg::S_IDLE;
        endcase
    end

    // outputs and divider requests
    always_comb begin
        o_in_stall       = (r_state != sfs_pkg::S_IDLE);
        o_res_valid      = (r_state == sfs_pkg::S_DONE);
        div_req.start    = 1'b0;
        div_req.dividend = freq_mag;
        div_req.divisor  = 9'(rd_len);
        case (r_state)
            sfs_pkg::S_WRAP_GO: begin
                div_req.start = (rd_len != 8'd0);
            end
            sfs_pkg::S_CELL_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = 16'(abs_frame);
                div_req.divisor  = cols;
            end
            default: ;
        endcase
    end

    sfs_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // result transaction
    assign anim_ext       = {4'd0, r_sel_anim};
    assign o_res.anim     = anim_ext[3:0];
    assign o_res.frame    = r_sel_frame;
    assign o_res.rect_x   = r_cell_x;
    assign o_res.rect_y   = r_cell_y;
    assign o_res.changed  = r_changed;
    assign o_res.rejected = r_rejected;

endmodule

`default_nettype wire

// ===== rtl/core/sprite_frame_sequencer_top.sv =====
// Sprite frame sequencer top level: configuration registers and result register.
//
// Input channel (i_in_valid / o_in_stall) carries one item: mode, anim_index,
// frame_number, entry_length. Output channel (o_out_valid / i_out_stall) returns
// exactly one result transaction per item. A transaction moves at a rising edge
// where valid is high and stall is low.
// Append, unused modes, steps that do not reach zero and any item met while the
// table is empty pass through the done state into the result register. A
// recompute (select, set frame, or a step whose countdown expires) does a
// table read, two 16-step passes of the shared restoring divider (frame wrap,
// skipped for a zero-length entry, and column split) and two multiplies by the
// cell size. The next item is taken once the result has left the done state.
// One item is processed at a time; o_in_stall is high while it is in work.
// The result register frees the sequencer, so the next item can be accepted
// while a result waits; if the receiver stalls a second result is held back.
// Configuration writes (i_cfg_we) take effect at once; the user must make them
// only while idle, as the block does not enforce it.
// Synchronous active-low reset clears the table count, selection, countdown
// (to one) and registers to origin 0,0, cell 1x1, one column, delay one.
`default_nettype none

module sprite_frame_sequencer_top #(
    parameter int unsigned MAX_ANIMATIONS   = 16,
    parameter int unsigned MAX_ENTRY_LENGTH = 255
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [2:0]                     i_mode,
    input  wire logic signed [15:0]             i_anim_index,
    input  wire logic signed [15:0]             i_frame_number,
    input  wire logic [7:0]                     i_entry_length,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [3:0]                          o_current_animation,
    output logic [7:0]                          o_current_frame,
    output logic [19:0]                         o_rect_x,
    output logic [22:0]                         o_rect_y,
    output logic                                o_changed,
    output logic                                o_rejected
);

    sfs_pkg::t_cfg        r_cfg;
    sfs_pkg::t_delay_load delay_load;
    sfs_pkg::t_result     res;
    sfs_pkg::t_result     r_out;
    logic                 r_out_valid;
    logic                 res_valid;
    logic                 res_take;
    logic [15:0]          delay_sat;

    // zero delay acts as one
    assign delay_sat = (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;

    assign delay_load.load  = i_cfg_we && (i_cfg_index == sfs_pkg::REG_FRAME_DELAY);
    assign delay_load.value = delay_sat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= 12'd0;
            r_cfg.origin_y      <= 12'd0;
            r_cfg.cell_width    <= 11'd1;
            r_cfg.cell_height   <= 11'd1;
            r_cfg.strip_columns <= 9'd1;
            r_cfg.frame_delay   <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfs_pkg::REG_ORIGIN_X:      r_cfg.origin_x      <= i_cfg_data[11:0];
                sfs_pkg::REG_ORIGIN_Y:      r_cfg.origin_y      <= i_cfg_data[11:0];
                sfs_pkg::REG_CELL_WIDTH:    r_cfg.cell_width    <= i_cfg_data[10:0];
                sfs_pkg::REG_CELL_HEIGHT:   r_cfg.cell_height   <= i_cfg_data[10:0];
                sfs_pkg::REG_STRIP_COLUMNS: r_cfg.strip_columns <= i_cfg_data[8:0];
                sfs_pkg::REG_FRAME_DELAY:   r_cfg.frame_delay   <= delay_sat;
                default: ;
            endcase
        end
    end

    sfs_seq #(
        .MAX_ANIMATIONS   (MAX_ANIMATIONS),
        .MAX_ENTRY_LENGTH (MAX_ENTRY_LENGTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_delay_load   (delay_load),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_anim_index   (i_anim_index),
        .i_frame_number (i_frame_number),
        .i_entry_length (i_entry_length),
        .o_res_valid    (res_valid),
        .i_res_take     (res_take),
        .o_res          (res)
    );

    // result register, refilled when empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_current_animation = r_out.anim;
    assign o_current_frame     = r_out.frame;
    assign o_rect_x            = r_out.rect_x;
    assign o_rect_y            = r_out.rect_y;
    assign o_changed           = r_out.changed;
    assign o_rejected          = r_out.rejected;

endmodule

`default_nettype wire
